### sv/bm3_pkg.sv
// Shared types, constants and helper functions for the 3x3 border-aware box mean.
// Used by bm3_ctrl, bm3_datapath and the top level box_mean_3x3_border_aware.
// Depends on nothing.
package bm3_pkg;

   // Default capacity of the line stores and of the row counter.
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   // Field widths.
   localparam int PIX_W  = 8;
   localparam int POS_W  = 10;
   localparam int SIZE_W = 11;

   // Size registers come out of reset at 64 pixels by 64 rows.
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd64;

   // Configuration register indexes.
   localparam int                 CSR_IDX_W        = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // Window sum, neighbor count and reciprocal scaling.
   localparam int SUM_W       = 12;   // nine pixels of 8 bits
   localparam int CNT_W       = 4;    // neighbor count 1..9
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = SUM_W + RECIP_W;

   // Number of candidate results per input pixel.
   localparam int NUM_CAND = 4;

   // ceil(2^16 / d). For every sum below 4096 the product, shifted right by
   // 16, equals the truncated quotient, since the rounding error of each
   // entry times 4096 stays below 2^16.
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] r;
      r = '0;
      case (cnt)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         4'd9:    r = 17'd7282;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       take;       // pixel transaction accepted this cycle
      logic       rd_en;      // read one window column from the line stores
      logic [1:0] rd_phase;   // which of the three window columns
      logic       mul_en;     // scale the window sum by the reciprocal
      logic       load_out;   // load the result register
      logic       sel_col;    // result column is the current column (else one left)
      logic       sel_row;    // result row is the current row (else one up)
      logic       last;       // final result caused by this pixel
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [NUM_CAND-1:0] cand;      // results the next pixel will cause
      logic                out_busy;  // result register full and not taken
   } status_type;

endpackage

### sv/bm3_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the line stores of the box mean. No dependencies.
module bm3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bm3_datapath.sv
// Datapath of the box mean: size registers, pixel position counters, three line
// stores, window accumulator, reciprocal multiplier and result register.
// Depends on bm3_pkg and bm3_ram.
module bm3_datapath #(
   parameter int MAX_WIDTH  = bm3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bm3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bm3_pkg::cmd_type                    cmd,
   output bm3_pkg::status_type                 status,
   input  logic [bm3_pkg::PIX_W-1:0]           req_pixel_value,
   input  logic                                csr_write_en,
   input  logic [bm3_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bm3_pkg::SIZE_W-1:0]          csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bm3_pkg::PIX_W-1:0]           rsp_mean_value,
   output logic [bm3_pkg::POS_W-1:0]           rsp_out_column,
   output logic [bm3_pkg::POS_W-1:0]           rsp_out_row,
   output logic                                rsp_last_of_run,
   output logic                                rsp_frame_done
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SW    = bm3_pkg::SIZE_W;
   localparam int PW    = bm3_pkg::PIX_W;
   localparam int QW    = bm3_pkg::POS_W;
   localparam int TAP_W = COL_W + 2;
   localparam logic [SW-1:0] WIDTH_CAP  =
      (MAX_WIDTH >= (2 ** SW)) ? '1 : SW'(MAX_WIDTH);
   localparam logic [SW-1:0] HEIGHT_CAP =
      (MAX_HEIGHT >= (2 ** SW)) ? '1 : SW'(MAX_HEIGHT);

   // Size registers and effective sizes.
   logic [SW-1:0] width_ff, width_in, height_ff, height_in;
   logic [SW-1:0] w_eff, h_eff;
   logic          csr_hit;

   // Position of the next pixel and the line store that holds its row.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [1:0]       slot_ff, slot_in;
   logic             last_col, last_row;

   // Position of the pixel being worked on.
   logic [COL_W-1:0] cur_c_ff, cur_c_in;
   logic [ROW_W-1:0] cur_r_ff, cur_r_in;
   logic [1:0]       cur_slot_ff, cur_slot_in;

   // Window of the current result.
   logic [COL_W-1:0]           res_x;
   logic [ROW_W-1:0]           res_y;
   logic [TAP_W-1:0]           tap;
   logic                       tap_ok;
   logic [COL_W-1:0]           rd_addr;
   logic [1:0]                 slot_up, slot_down;
   logic [2:0]                 row_inc;
   logic [1:0]                 n_rows, n_cols;
   logic [bm3_pkg::CNT_W-1:0]  n_cells;
   logic [PW-1:0]              rd_data [3];
   logic [PW+1:0]              col_sum;

   logic                       rd_valid_ff, rd_valid_in;
   logic [bm3_pkg::SUM_W-1:0]  acc_ff, acc_in;
   logic [bm3_pkg::PROD_W-1:0] prod_ff, prod_in;

   // Result register.
   logic          out_valid_ff, out_valid_in;
   logic [PW-1:0] out_mean_ff, out_mean_in;
   logic [QW-1:0] out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic          out_last_ff, out_last_in, out_done_ff, out_done_in;

   // Size registers: zero means one, anything above the store width or row counter capacity saturates.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      csr_hit   = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            bm3_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_write_data;
               csr_hit  = 1'b1;
            end
            bm3_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_write_data;
               csr_hit   = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   assign w_eff = (width_ff == '0) ? SW'(1) :
                  (width_ff > WIDTH_CAP) ? WIDTH_CAP : width_ff;
   assign h_eff = (height_ff == '0) ? SW'(1) :
                  (height_ff > HEIGHT_CAP) ? HEIGHT_CAP : height_ff;

   assign last_col = (32'(col_ff) + 32'd1) == 32'(w_eff);
   assign last_row = (32'(row_ff) + 32'd1) == 32'(h_eff);

   // Results the next pixel causes, in delivery order.
   assign status.cand[0]  = (row_ff != '0) && (col_ff != '0);
   assign status.cand[1]  = (row_ff != '0) && last_col;
   assign status.cand[2]  = last_row && (col_ff != '0);
   assign status.cand[3]  = last_row && last_col;
   assign status.out_busy = out_valid_ff && !rsp_ready;

   // Raster position counters. A size write restarts the frame.
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      slot_in     = slot_ff;
      cur_c_in    = cur_c_ff;
      cur_r_in    = cur_r_ff;
      cur_slot_in = cur_slot_ff;
      if (csr_hit) begin
         col_in  = '0;
         row_in  = '0;
         slot_in = 2'd0;
      end else if (cmd.take) begin
         cur_c_in    = col_ff;
         cur_r_in    = row_ff;
         cur_slot_in = slot_ff;
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in  = '0;
               slot_in = 2'd0;
            end else begin
               row_in  = row_ff + ROW_W'(1);
               slot_in = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // Centre of the result: one column left and/or one row up from the pixel.
   assign res_x = cmd.sel_col ? cur_c_ff : cur_c_ff - COL_W'(1);
   assign res_y = cmd.sel_row ? cur_r_ff : cur_r_ff - ROW_W'(1);

   // Window column res_x - 1 + phase, kept one higher so it never goes negative.
   assign tap     = TAP_W'(res_x) + TAP_W'(cmd.rd_phase);
   assign tap_ok  = (tap != '0) && (32'(tap) <= 32'(w_eff));
   assign rd_addr = tap_ok ? COL_W'(tap - TAP_W'(1)) : '0;

   // Line stores of the rows above and below the current pixel's row. The store
   // below holds row r-2 until row r+1 starts to overwrite it.
   assign slot_up   = (cur_slot_ff == 2'd0) ? 2'd2 : cur_slot_ff - 2'd1;
   assign slot_down = (cur_slot_ff == 2'd2) ? 2'd0 : cur_slot_ff + 2'd1;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         row_inc[i] = (2'(i) == cur_slot_ff) ||
                      ((2'(i) == slot_up) && (cur_r_ff != '0)) ||
                      ((2'(i) == slot_down) && !cmd.sel_row &&
                       (32'(cur_r_ff) >= 32'd2));
      end
   end

   // Neighbor count: rows times columns inside the image.
   assign n_rows  = 2'd1 + 2'(cur_r_ff != '0) +
                    2'((!cmd.sel_row) && (32'(cur_r_ff) >= 32'd2));
   assign n_cols  = 2'd1 + 2'(res_x != '0) +
                    2'((32'(res_x) + 32'd1) < 32'(w_eff));
   assign n_cells = {2'b00, n_rows} * {2'b00, n_cols};

   for (genvar g = 0; g < 3; g++) begin : g_store
      bm3_ram #(
         .WIDTH (PW),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (cmd.take && (cur_slot_in == 2'(g))),
         .wr_addr (col_ff),
         .wr_data (req_pixel_value),
         .rd_en   (cmd.rd_en),
         .rd_addr (rd_addr),
         .rd_data (rd_data[g])
      );
   end

   assign col_sum = (row_inc[0] ? (PW+2)'(rd_data[0]) : '0) +
                    (row_inc[1] ? (PW+2)'(rd_data[1]) : '0) +
                    (row_inc[2] ? (PW+2)'(rd_data[2]) : '0);

   always_comb begin
      rd_valid_in = cmd.rd_en && tap_ok;
      acc_in      = acc_ff;
      prod_in     = prod_ff;
      if (cmd.rd_en && (cmd.rd_phase == 2'd0)) begin
         acc_in = '0;
      end else if (rd_valid_ff) begin
         acc_in = acc_ff + bm3_pkg::SUM_W'(col_sum);
      end
      if (cmd.mul_en) begin
         prod_in = bm3_pkg::PROD_W'(acc_ff) *
                   bm3_pkg::PROD_W'(bm3_pkg::recip(n_cells));
      end
   end

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_mean_in  = out_mean_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_mean_in  = prod_ff[bm3_pkg::RECIP_SHIFT +: PW];
         out_col_in   = QW'(res_x);
         out_row_in   = QW'(res_y);
         out_last_in  = cmd.last;
         out_done_in  = ((32'(res_x) + 32'd1) == 32'(w_eff)) &&
                        ((32'(res_y) + 32'd1) == 32'(h_eff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bm3_pkg::SIZE_RESET;
         height_ff    <= bm3_pkg::SIZE_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= 2'd0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         slot_ff      <= slot_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_c_ff    <= cur_c_in;
      cur_r_ff    <= cur_r_in;
      cur_slot_ff <= cur_slot_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      out_mean_ff <= out_mean_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_mean_value  = out_mean_ff;
   assign rsp_out_column  = out_col_ff;
   assign rsp_out_row     = out_row_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_frame_done  = out_done_ff;

endmodule

### sv/bm3_ctrl.sv
// Controller of the box mean: accepts pixels and walks the results each pixel
// causes through read, accumulate, scale and output steps.
// Depends on bm3_pkg.
module bm3_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bm3_pkg::status_type status,
   output bm3_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   localparam int NC = bm3_pkg::NUM_CAND;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;
   logic [NC-1:0] pend_ff, pend_in;
   logic [NC-1:0] first;

   // Results go out lowest candidate first.
   assign first = pend_ff & (~pend_ff + NC'(1));

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.sel_col  = first[1] || first[3];
      cmd.sel_row  = first[2] || first[3];
      cmd.last     = (pend_ff & ~first) == '0;
      cmd.rd_phase = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               pend_in  = status.cand;
               phase_in = 2'd0;
               if (status.cand != '0) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            if (phase_ff == 2'd2) begin
               phase_in = 2'd0;
               state_in = ST_DRAIN;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               pend_in      = pend_ff & ~first;
               phase_in     = 2'd0;
               state_in     = cmd.last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 2'd0;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
      end
   end

   // Work is only ever under way while some result is still owed.
   a_pending_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (pend_ff != '0))
      else $error("controller busy with no result pending");

   // The last window column is only drained after it was read.
   a_drain_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (($past(state_ff) == ST_READ) &&
                                  ($past(phase_ff) == 2'd2)))
      else $error("drain step without a completed column read");

   // A new pixel always starts its first window at column phase zero.
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (phase_ff == 2'd0))
      else $error("column phase not cleared while idle");

endmodule

### sv/box_mean_3x3_border_aware.sv
// Each result that a pixel transaction causes (0 to 4) is worked through in turn:
// three line store reads, a drain step, the multiply, and the load of the result
// register, which waits while that register is full and not taken. A new pixel is
// accepted only once every result of the previous one has been loaded.
// Reset (synchronous, active high) clears the controller, the position counters and
// the result valid, and sets both size registers to 64; line stores are not cleared.
module box_mean_3x3_border_aware #(
   parameter int MAX_WIDTH  = bm3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bm3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Pixel input channel.
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bm3_pkg::PIX_W-1:0]     req_pixel_value,
   // Result channel.
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bm3_pkg::PIX_W-1:0]     rsp_mean_value,
   output logic [bm3_pkg::POS_W-1:0]     rsp_out_column,
   output logic [bm3_pkg::POS_W-1:0]     rsp_out_row,
   output logic                          rsp_last_of_run,
   output logic                          rsp_frame_done,
   // Configuration write port.
   input  logic                          csr_write_en,
   input  logic [bm3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bm3_pkg::SIZE_W-1:0]    csr_write_data
);

   // The controller accepts a pixel only when idle. The pixel is written to the
   // line store of its row in the same cycle, and the controller then works
   // through the results that pixel completes: the centre one row up and one
   // column left, the centre one row up at the end of a row, and on the last row
   // the centres of that row itself. Each window is read one column per cycle
   // from the three line stores, summed, and scaled by a reciprocal of its
   // neighbor count. The result register lets the next pixel transaction be
   // accepted while the final result of the previous one waits to be taken.
   bm3_pkg::cmd_type    cmd;
   bm3_pkg::status_type status;

   bm3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bm3_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_pixel_value (req_pixel_value),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_row     (rsp_out_row),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done)
   );

endmodule
